FILE: hw/rtl/pfi_pkg.sv
// Shared constants, state codes and character helpers for the printf format
// interpreter. No dependencies; pfi_dabble and the top level import this package.
`default_nettype none
package pfi_pkg;

  // Largest pad run is PAD_LIMIT-2 characters.
  localparam int PAD_LIMIT = 16;
  localparam int PAD_W     = $clog2(PAD_LIMIT);

  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = 8;
  localparam int DIG_W      = 4 * DEC_DIGITS;

  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_C     = 8'h63;  // 'c'
  localparam logic [7:0] CH_D     = 8'h64;  // 'd'
  localparam logic [7:0] CH_I     = 8'h69;  // 'i'
  localparam logic [7:0] CH_U     = 8'h75;  // 'u'
  localparam logic [7:0] CH_X_LO  = 8'h78;  // 'x'
  localparam logic [7:0] CH_X_UP  = 8'h58;  // 'X'
  localparam logic [7:0] CH_P     = 8'h70;  // 'p'

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHAR   = 9'b000000010,
    S_ERR    = 9'b000000100,
    S_CONV   = 9'b000001000,
    S_NORM   = 9'b000010000,
    S_MINUS1 = 9'b000100000,
    S_PAD    = 9'b001000000,
    S_MINUS2 = 9'b010000000,
    S_DIGITS = 9'b100000000
  } pfi_state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    unique case (d)
      4'h0: c = 8'h30;  4'h1: c = 8'h31;  4'h2: c = 8'h32;  4'h3: c = 8'h33;
      4'h4: c = 8'h34;  4'h5: c = 8'h35;  4'h6: c = 8'h36;  4'h7: c = 8'h37;
      4'h8: c = 8'h38;  4'h9: c = 8'h39;  4'ha: c = 8'h61;  4'hb: c = 8'h62;
      4'hc: c = 8'h63;  4'hd: c = 8'h64;  4'he: c = 8'h65;  default: c = 8'h66;
    endcase
    return c;
  endfunction

  // "ERROR", one character per index.
  function automatic logic [7:0] err_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0, 3'd3: c = 8'h45;  // 'E'
      3'd4:       c = 8'h52;  // 'R'
      3'd1, 3'd2: c = 8'h52;  // 'R'
      default:    c = 8'h4f;  // 'O'
    endcase
    if (idx == 3'd3) c = 8'h4f;
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/pfi_if.sv
// Valid/ready channel interfaces for format items and output characters.
// Depends on nothing; used by the top level.
`default_nettype none
interface pfi_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  format_byte;
  logic [31:0] argument;

  modport source (output valid, output format_byte, output argument, input ready);
  modport sink   (input valid, input format_byte, input argument, output ready);
endinterface

interface pfi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/pfi_dabble.sv
// Bit-serial binary to BCD converter (shift and add three), one bit a cycle.
// Depends on pfi_pkg for the digit count.
`default_nettype none
module pfi_dabble
  import pfi_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [31:0]      value,
  output logic                  done,
  output logic [DIG_W-1:0]      bcd
);

  logic [31:0]      sh_r;
  logic [DIG_W-1:0] bcd_r;
  logic [DIG_W-1:0] adj;
  logic [4:0]       bit_cnt_r;
  logic             busy_r;
  logic             done_r;

  // Correct every digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3 : bcd_r[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
      bit_cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r    <= 1'b1;
        bit_cnt_r <= '0;
      end else if (busy_r) begin
        bit_cnt_r <= bit_cnt_r + 5'd1;
        if (bit_cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= value;
      bcd_r <= '0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[30:0], 1'b0};
      bcd_r <= {adj[DIG_W-2:0], sh_r[31]};
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule
`default_nettype wire

FILE: hw/rtl/printf_format_interpreter_unit.sv
// Top level of the printf format interpreter: spec parser, output sequencer
// and output register. Depends on pfi_pkg, pfi_if and pfi_dabble.
`default_nettype none
// One format byte is taken per item, only while the sequencer is idle. A byte
// outside a spec, '%%', 'c' and error bytes are accepted and then emit their
// characters. A byte that opens a spec or adds a width digit emits nothing and
// leaves the unit ready in the next cycle. Hex conversions strip leading
// zeros after the accept, then emit their characters one at a time.
// Decimal conversions add the serial BCD converter: it is started, shifts
// in the argument one bit at a time and is loaded back; then leading zeros
// are stripped and the characters are emitted one at a time.
// Characters leave through a single output register, so one character can
// wait for the sink while the next is formed; a stalled sink stalls the
// sequencer. The last character of any item that emits one carries last = 1.
module printf_format_interpreter_unit
  import pfi_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  pfi_in_if.sink     in_ch,
  pfi_out_if.source  out_ch
);

  pfi_state_t state_r, state_nxt;

  // Spec state kept between items.
  logic       in_spec_r, in_spec_nxt;
  logic [7:0] fw_r, fw_nxt;
  logic       zf_r, zf_nxt;

  // Work registers of the conversion in flight.
  logic [7:0]       wid_r, wid_nxt;
  logic             zfl_r, zfl_nxt;
  logic             neg_r, neg_nxt;
  logic [7:0]       char_r, char_nxt;
  logic [DIG_W-1:0] dig_r, dig_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [PAD_W-1:0] pad_r, pad_nxt;
  logic             pad_ok_r, pad_ok_nxt;
  logic [2:0]       idx_r, idx_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;

  logic             conv_start;
  logic [31:0]      conv_value;
  logic             conv_done;
  logic [DIG_W-1:0] conv_bcd;

  logic             accept;
  logic             emit_ok;
  logic [7:0]       b;
  logic [31:0]      arg;
  logic [11:0]      wsum;
  logic [9:0]       pad_s;
  logic             pad_fit;
  logic [3:0]       top_dig;

  pfi_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .value (conv_value),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign emit_ok     = !out_valid_r || out_ch.ready;
  assign b           = in_ch.format_byte;
  assign arg         = in_ch.argument;
  assign top_dig     = dig_r[DIG_W-1 -: 4];

  // Width accumulation, saturating at 255.
  assign wsum = ({4'd0, fw_r} * 12'd10) + {4'd0, b - CH_ZERO};

  // Pad count once the digit count is settled.
  assign pad_s   = {2'b00, wid_r} - {6'd0, cnt_r} - {9'd0, neg_r};
  assign pad_fit = !pad_s[9] && (pad_s != 10'd0) && (pad_s <= 10'(PAD_LIMIT - 2));

  // The converter is started from a registered argument.
  assign conv_value = {dig_r[DIG_W-1 -: 32]};

  always_comb begin
    state_nxt     = state_r;
    in_spec_nxt   = in_spec_r;
    fw_nxt        = fw_r;
    zf_nxt        = zf_r;
    wid_nxt       = wid_r;
    zfl_nxt       = zfl_r;
    neg_nxt       = neg_r;
    char_nxt      = char_r;
    dig_nxt       = dig_r;
    cnt_nxt       = cnt_r;
    pad_nxt       = pad_r;
    pad_ok_nxt    = pad_ok_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    conv_start    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_spec_r) begin
            if (b == CH_PCT) begin
              // Open a spec.
              in_spec_nxt = 1'b1;
              fw_nxt      = '0;
              zf_nxt      = 1'b0;
            end else begin
              char_nxt  = b;
              state_nxt = S_CHAR;
            end
          end else if (b >= CH_ZERO && b <= CH_NINE) begin
            if (b == CH_ZERO && fw_r == 8'd0) zf_nxt = 1'b1;
            fw_nxt = (wsum > 12'd255) ? 8'd255 : wsum[7:0];
          end else begin
            // Close the spec; keep width and fill for this conversion.
            in_spec_nxt = 1'b0;
            fw_nxt      = '0;
            zf_nxt      = 1'b0;
            wid_nxt     = fw_r;
            zfl_nxt     = zf_r;
            neg_nxt     = 1'b0;
            priority if (b == CH_C) begin
              char_nxt  = arg[7:0];
              state_nxt = S_CHAR;
            end else if (b == CH_PCT) begin
              char_nxt  = CH_PCT;
              state_nxt = S_CHAR;
            end else if (b == CH_D || b == CH_I) begin
              neg_nxt   = arg[31];
              dig_nxt   = {(arg[31] ? (32'd0 - arg) : arg), 8'd0};
              state_nxt = S_CONV;
            end else if (b == CH_U) begin
              dig_nxt   = {arg, 8'd0};
              state_nxt = S_CONV;
            end else if (b == CH_X_LO || b == CH_X_UP || b == CH_P) begin
              dig_nxt   = {arg, 8'd0};
              cnt_nxt   = 4'(HEX_DIGITS);
              state_nxt = S_NORM;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_ERR;
            end
          end
        end
      end

      S_CHAR: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = char_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_ERR: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = err_char(idx_r);
          out_last_nxt  = (idx_r == 3'd4);
          idx_nxt       = idx_r + 3'd1;
          if (idx_r == 3'd4) state_nxt = S_IDLE;
        end
      end

      S_CONV: begin
        // Kick the converter once (cnt_r marks the start), then wait.
        if (cnt_r != 4'hf) begin
          conv_start = 1'b1;
          cnt_nxt    = 4'hf;
        end else if (conv_done) begin
          dig_nxt   = conv_bcd;
          cnt_nxt   = 4'(DEC_DIGITS);
          state_nxt = S_NORM;
        end
      end

      S_NORM: begin
        // Drop leading zero digits, keep at least one.
        if (cnt_r > 4'd1 && top_dig == 4'd0) begin
          dig_nxt = {dig_r[DIG_W-5:0], 4'd0};
          cnt_nxt = cnt_r - 4'd1;
        end else begin
          pad_nxt    = pad_s[PAD_W-1:0];
          pad_ok_nxt = pad_fit;
          priority if (neg_r && zfl_r) state_nxt = S_MINUS1;
          else if (pad_fit)            state_nxt = S_PAD;
          else if (neg_r)              state_nxt = S_MINUS2;
          else                         state_nxt = S_DIGITS;
        end
      end

      S_MINUS1: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = pad_ok_r ? S_PAD : S_DIGITS;
        end
      end

      S_PAD: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = zfl_r ? CH_ZERO : CH_SPACE;
          out_last_nxt  = 1'b0;
          pad_nxt       = pad_r - PAD_W'(1);
          if (pad_r == PAD_W'(1)) state_nxt = (neg_r && !zfl_r) ? S_MINUS2 : S_DIGITS;
        end
      end

      S_MINUS2: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = S_DIGITS;
        end
      end

      S_DIGITS: begin
        // Emit the top digit and advance the digit shift register.
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(top_dig);
          out_last_nxt  = (cnt_r == 4'd1);
          dig_nxt       = {dig_r[DIG_W-5:0], 4'd0};
          cnt_nxt       = cnt_r - 4'd1;
          if (cnt_r == 4'd1) state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_spec_r   <= 1'b0;
      fw_r        <= '0;
      zf_r        <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      in_spec_r   <= in_spec_nxt;
      fw_r        <= fw_nxt;
      zf_r        <= zf_nxt;
      out_valid_r <= out_valid_nxt;
      // Clear the start mark on entry to the converter wait.
      cnt_r       <= (state_r == S_IDLE && state_nxt == S_CONV) ? 4'd0 : cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wid_r      <= wid_nxt;
    zfl_r      <= zfl_nxt;
    neg_r      <= neg_nxt;
    char_r     <= char_nxt;
    dig_r      <= dig_nxt;
    pad_r      <= pad_nxt;
    pad_ok_r   <= pad_ok_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;
  assign out_ch.last     = out_last_r;

endmodule
`default_nettype wire
